>>> hdl/ridf_pkg.sv
// Shared types, codes and the identifier normalization function for the duplicate filter.
package ridf_pkg;

	localparam int ID_W       = 48;
	localparam int ID_BYTES   = ID_W / 8;
	localparam int COUNT_OUT_W = 5;

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_INSERT = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t            command;
		logic [ID_W-1:0] packet_id;
	} in_item_t;

	typedef struct packed {
		logic                   found;
		logic [COUNT_OUT_W-1:0] stored_count;
	} out_item_t;

	function automatic logic [ID_W-1:0] normalize_id(input logic [ID_W-1:0] raw, input int chars);
		logic [ID_W-1:0] kept;
		logic            live;
		kept = '0;
		live = 1'b1;
		for (int i = 0; i < ID_BYTES; i++) begin
			if (raw[8*i +: 8] == 8'h00 || i >= chars) begin
				live = 1'b0;
			end
			if (live) begin
				kept[8*i +: 8] = raw[8*i +: 8];
			end
		end
		return kept;
	endfunction

endpackage

>>> hdl/recent_id_duplicate_filter_core.sv
// Top level of the recent-identifier duplicate filter.
// Accepts one lookup or insert transaction per cycle unless cmd_stall is high, and returns one
// result per transaction: the identifier is normalized into an input register at acceptance,
// then all HISTORY_DEPTH entries are compared in parallel and the found flag and the entry
// count land in the result register. A stalled result holds a transaction in the input
// register and stalls the command channel in the same cycle. The history holds the last
// HISTORY_DEPTH inserts with oldest-first replacement; valid marks clear at reset, so no
// clearing pass is needed.
module recent_id_duplicate_filter_core #(
	parameter int HISTORY_DEPTH = 16,
	parameter int ID_CHARS      = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  ridf_pkg::in_item_t  cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output ridf_pkg::out_item_t res
);

	logic                valid_s1;
	ridf_pkg::in_item_t  item_s1;
	logic                res_valid_q;
	ridf_pkg::out_item_t res_q;
	ridf_pkg::out_item_t cam_result;
	logic                out_free;
	logic                advance;
	logic                accept;

	assign out_free  = !res_valid_q || !res_stall;
	assign advance   = valid_s1 && out_free;
	assign cmd_stall = valid_s1 && !out_free;
	assign accept    = cmd_valid && !cmd_stall;

	ridf_cam #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_cam (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (advance),
		.op    (item_s1),
		.result(cam_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!cmd_stall) begin
				valid_s1 <= cmd_valid;
			end
			if (out_free) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command   <= cmd.command;
			item_s1.packet_id <= ridf_pkg::normalize_id(cmd.packet_id, ID_CHARS);
		end
		if (advance) begin
			res_q <= cam_result;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> hdl/ridf_cam.sv
// Identifier history: FIFO-replaced entries with a parallel compare across all valid entries.
module ridf_cam #(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  ridf_pkg::in_item_t op,
	output ridf_pkg::out_item_t result
);

	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int EXT_W  = CNT_W + ridf_pkg::COUNT_OUT_W;

	logic [ridf_pkg::ID_W-1:0] id_store [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0]  entry_valid_q;
	logic [SLOT_W-1:0]         oldest_q;
	logic [CNT_W-1:0]          count_q;

	logic                      full;
	logic                      insert;
	logic [SLOT_W-1:0]         slot;
	logic [CNT_W-1:0]          next_count;
	logic [EXT_W-1:0]          count_ext;
	logic [HISTORY_DEPTH-1:0]  hit;

	assign full   = (count_q == CNT_W'(HISTORY_DEPTH));
	assign insert = (op.command == ridf_pkg::CMD_INSERT);
	assign slot   = full ? oldest_q : SLOT_W'(count_q);

	always_comb begin
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			hit[i] = entry_valid_q[i] && (id_store[i] == op.packet_id);
		end
	end

	assign next_count          = (insert && !full) ? count_q + CNT_W'(1) : count_q;
	assign count_ext           = EXT_W'(next_count);
	assign result.found        = !insert && (|hit);
	assign result.stored_count = count_ext[ridf_pkg::COUNT_OUT_W-1:0];

	always_ff @(posedge clk) begin
		if (go && insert) begin
			id_store[slot] <= op.packet_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			oldest_q      <= '0;
			count_q       <= '0;
		end else if (go && insert) begin
			entry_valid_q[slot] <= 1'b1;
			count_q             <= next_count;
			if (full) begin
				// advance oldest pointer, wrap at depth
				oldest_q <= (oldest_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : oldest_q + SLOT_W'(1);
			end
		end
	end

endmodule
